// ===== hw/rtl/cffp_pkg.sv =====
// cffp_pkg: shared constants, codes and types of the colon field frame parser
// used by cffp_frame_ctl, cffp_field_bank and colon_field_frame_parser
// no dependencies
package cffp_pkg;

    localparam int FRAME_CAPACITY = 254;
    localparam int FIELD_COUNT    = 6;
    localparam int OUT_FIELDS     = 6;
    localparam int VALUE_W        = 32;

    localparam int POS_W  = $clog2(FRAME_CAPACITY + 1);
    localparam int FNUM_W = $clog2(FIELD_COUNT + 1);
    localparam int IDX_W  = (FIELD_COUNT > 1) ? $clog2(FIELD_COUNT) : 1;

    localparam logic [7:0] CH_END   = 8'h3B; // ';'
    localparam logic [7:0] CH_TYPE  = 8'h30; // '0'
    localparam logic [7:0] CH_FIELD = 8'h3A; // ':'
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [1:0] {
        PH_SKIP   = 2'd0,
        PH_DIGITS = 2'd1,
        PH_STOP   = 2'd2
    } t_phase;

    typedef struct packed {
        logic             clear;
        logic             add;
        logic [IDX_W-1:0] idx;
        logic             neg;
        logic [3:0]       digit;
    } t_acc_ctl;

endpackage

// ===== hw/rtl/colon_field_frame_parser.sv =====
// colon_field_frame_parser: top level, input beat register, parse control,
// field accumulators and result register; depends on cffp_pkg,
// cffp_frame_ctl and cffp_field_bank
// a ';' beat is first held in the input beat register; when it moves on,
// its frame's values are captured in the result register and on the outputs
// throughput: one byte per cycle; the parse step is a single shift-and-add
// times ten with saturation between the two registers; the held byte only
// waits while it ends a frame and a full result register is not being taken
// reset: synchronous active-low i_rst_n clears both register valids,
// the frame state and all field values
module colon_field_frame_parser (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [7:0]                          i_byte_in,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [cffp_pkg::VALUE_W-1:0] o_value_0,
    output logic signed [cffp_pkg::VALUE_W-1:0] o_value_1,
    output logic signed [cffp_pkg::VALUE_W-1:0] o_value_2,
    output logic signed [cffp_pkg::VALUE_W-1:0] o_value_3,
    output logic signed [cffp_pkg::VALUE_W-1:0] o_value_4,
    output logic signed [cffp_pkg::VALUE_W-1:0] o_value_5
);

    // input beat register
    logic       r_in_vld;
    logic [7:0] r_in_byte;

    // result register
    logic                                r_out_vld;
    logic signed [cffp_pkg::VALUE_W-1:0] r_out [cffp_pkg::OUT_FIELDS];

    logic                                emit, advance;
    cffp_pkg::t_acc_ctl                  acc;
    logic signed [cffp_pkg::VALUE_W-1:0] bank [cffp_pkg::FIELD_COUNT];
    logic signed [cffp_pkg::VALUE_W-1:0] snap [cffp_pkg::OUT_FIELDS];

    // the held byte moves on unless it ends a frame with a result and the
    // result register is still full and not being taken
    assign advance = r_in_vld && (!emit || !r_out_vld || i_ready);
    assign o_ready = !r_in_vld || advance;

    cffp_frame_ctl u_ctl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_byte    (r_in_byte),
        .i_advance (advance),
        .o_emit    (emit),
        .o_acc     (acc)
    );

    cffp_field_bank u_bank (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_acc    (acc),
        .o_values (bank)
    );

    // fields beyond the configured count read as zero
    for (genvar j = 0; j < cffp_pkg::OUT_FIELDS; j++) begin : g_snap
        if (j < cffp_pkg::FIELD_COUNT) begin : g_live
            assign snap[j] = bank[j];
        end else begin : g_zero
            assign snap[j] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_ready) begin
            r_in_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte <= i_byte_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance && emit) begin
            r_out_vld <= 1'b1;
        end else if (i_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    // the bank still holds the frame's values while its ';' is processed
    always_ff @(posedge i_clk) begin
        if (advance && emit) begin
            r_out <= snap;
        end
    end

    assign o_valid   = r_out_vld;
    assign o_value_0 = r_out[0];
    assign o_value_1 = r_out[1];
    assign o_value_2 = r_out[2];
    assign o_value_3 = r_out[3];
    assign o_value_4 = r_out[4];
    assign o_value_5 = r_out[5];

endmodule

// ===== hw/rtl/cffp_frame_ctl.sv =====
// cffp_frame_ctl: frame position, frame type and per-field parse phase
// depends on cffp_pkg
module cffp_frame_ctl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [7:0]         i_byte,
    input  logic               i_advance,
    output logic               o_emit,
    output cffp_pkg::t_acc_ctl o_acc
);

    logic [cffp_pkg::POS_W-1:0]  r_pos,   n_pos;
    logic                        r_type,  n_type;
    logic [cffp_pkg::FNUM_W-1:0] r_fnum,  n_fnum;
    cffp_pkg::t_phase            r_phase, n_phase;
    logic                        r_neg,   n_neg;

    logic is_end, is_field, is_space, is_digit, in_body, field_open;

    assign is_end   = (i_byte == cffp_pkg::CH_END);
    assign is_field = (i_byte == cffp_pkg::CH_FIELD);
    assign is_space = (i_byte == cffp_pkg::CH_SPACE) ||
                      ((i_byte >= cffp_pkg::CH_TAB) && (i_byte <= cffp_pkg::CH_CR));
    assign is_digit = (i_byte >= cffp_pkg::CH_ZERO) && (i_byte <= cffp_pkg::CH_NINE);
    // bytes from the third onwards of a type '0' frame, within capacity
    assign in_body  = !is_end && (r_pos < cffp_pkg::POS_W'(cffp_pkg::FRAME_CAPACITY)) &&
                      (r_pos >= cffp_pkg::POS_W'(2)) && r_type;
    assign field_open = (r_fnum < cffp_pkg::FNUM_W'(cffp_pkg::FIELD_COUNT));

    // next state
    always_comb begin
        n_pos   = r_pos;
        n_type  = r_type;
        n_fnum  = r_fnum;
        n_phase = r_phase;
        n_neg   = r_neg;
        if (is_end) begin
            n_pos   = '0;
            n_type  = 1'b0;
            n_fnum  = '0;
            n_phase = cffp_pkg::PH_SKIP;
            n_neg   = 1'b0;
        end else if (r_pos < cffp_pkg::POS_W'(cffp_pkg::FRAME_CAPACITY)) begin
            n_pos = r_pos + cffp_pkg::POS_W'(1);
            if (r_pos == '0) begin
                n_type = (i_byte == cffp_pkg::CH_TYPE);
            end
            if (in_body) begin
                if (is_field) begin
                    if (field_open) begin
                        n_fnum = r_fnum + cffp_pkg::FNUM_W'(1);
                    end
                    n_phase = cffp_pkg::PH_SKIP;
                    n_neg   = 1'b0;
                end else if (field_open) begin
                    case (r_phase)
                        cffp_pkg::PH_SKIP: begin
                            if (!is_space) begin
                                if (i_byte == cffp_pkg::CH_MINUS) begin
                                    n_phase = cffp_pkg::PH_DIGITS;
                                    n_neg   = 1'b1;
                                end else if (i_byte == cffp_pkg::CH_PLUS || is_digit) begin
                                    n_phase = cffp_pkg::PH_DIGITS;
                                end else begin
                                    n_phase = cffp_pkg::PH_STOP;
                                end
                            end
                        end
                        cffp_pkg::PH_DIGITS: begin
                            if (!is_digit) begin
                                n_phase = cffp_pkg::PH_STOP;
                            end
                        end
                        default: n_phase = r_phase;
                    endcase
                end
            end
        end
    end

    // outputs
    always_comb begin
        o_emit      = is_end && (r_pos != '0) && r_type;
        o_acc.clear = i_advance && is_end;
        o_acc.add   = i_advance && in_body && !is_field && field_open && is_digit &&
                      ((r_phase == cffp_pkg::PH_SKIP) || (r_phase == cffp_pkg::PH_DIGITS));
        o_acc.idx   = r_fnum[cffp_pkg::IDX_W-1:0];
        o_acc.neg   = r_neg;
        o_acc.digit = i_byte[3:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_type  <= 1'b0;
            r_fnum  <= '0;
            r_phase <= cffp_pkg::PH_SKIP;
            r_neg   <= 1'b0;
        end else if (i_advance) begin
            r_pos   <= n_pos;
            r_type  <= n_type;
            r_fnum  <= n_fnum;
            r_phase <= n_phase;
            r_neg   <= n_neg;
        end
    end

endmodule

// ===== hw/rtl/cffp_field_bank.sv =====
// cffp_field_bank: running field values with saturating times-ten accumulate
// depends on cffp_pkg
module cffp_field_bank (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  cffp_pkg::t_acc_ctl                  i_acc,
    output logic signed [cffp_pkg::VALUE_W-1:0] o_values [cffp_pkg::FIELD_COUNT]
);

    localparam int SUM_W = cffp_pkg::VALUE_W + 5;

    logic signed [cffp_pkg::VALUE_W-1:0] r_val [cffp_pkg::FIELD_COUNT];
    logic signed [cffp_pkg::VALUE_W-1:0] cur, n_val;
    logic signed [SUM_W-1:0]             cur_ext, prod, sum, dig;

    localparam logic signed [SUM_W-1:0] SAT_MAX =
        SUM_W'({1'b0, {(cffp_pkg::VALUE_W-1){1'b1}}});
    localparam logic signed [SUM_W-1:0] SAT_MIN = -SAT_MAX - SUM_W'(1);

    always_comb begin
        cur     = r_val[i_acc.idx];
        cur_ext = SUM_W'(cur);
        // times ten as shift-and-add
        prod    = (cur_ext <<< 3) + (cur_ext <<< 1);
        dig     = SUM_W'({1'b0, i_acc.digit});
        sum     = i_acc.neg ? (prod - dig) : (prod + dig);
        if (sum > SAT_MAX) begin
            n_val = cffp_pkg::VALUE_W'(SAT_MAX);
        end else if (sum < SAT_MIN) begin
            n_val = cffp_pkg::VALUE_W'(SAT_MIN);
        end else begin
            n_val = sum[cffp_pkg::VALUE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_acc.clear) begin
            for (int k = 0; k < cffp_pkg::FIELD_COUNT; k++) begin
                r_val[k] <= '0;
            end
        end else if (i_acc.add) begin
            r_val[i_acc.idx] <= n_val;
        end
    end

    assign o_values = r_val;

endmodule
